/* rtl/distance_vector_route_table_assert.svh */
// Assertion macros shared by the route table RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DVRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dvrt_pkg.sv */
// Package for the distance-vector route table: request and result types,
// command and status codes, sizing constants and the saturating increment.
// Depends on nothing.
`default_nettype none

package dvrt_pkg;

    localparam int DVRT_TABLE_DEPTH = 256;
    localparam int QUEUE_DEPTH      = 2;
    localparam int ADDR_W           = 8;
    localparam int COST_W           = 8;

    typedef enum logic [1:0] {
        CMD_LOCAL  = 2'd0,
        CMD_ADV    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_DOWN   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_SKIPPED = 2'd1,
        STS_UNKNOWN = 2'd2,
        STS_ZERO    = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ADDR_W-1:0]   dest_addr;
        logic [ADDR_W-1:0]   adv_hop;
        logic [COST_W-1:0]   adv_cost;
        logic [ADDR_W-1:0]   src_addr;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   route_hop;
        logic [COST_W-1:0]   route_cost;
    } rsp_t;

    // Request after classification by the front end.
    typedef struct packed {
        req_t req;
        logic in_table;
        logic dest_zero;
    } item_t;

    // Value of paddr[2] that selects the infinity-cost register.
    localparam logic CFG_IDX_INF = 1'b0;

    function automatic logic [COST_W-1:0] sat_inc(
        input logic [COST_W-1:0] c,
        input logic [COST_W-1:0] inf
    );
        logic [COST_W:0] s;
        s = {1'b0, c} + {{COST_W{1'b0}}, 1'b1};
        if (s > {1'b0, inf})
            return inf;
        return s[COST_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/dvrt_front.sv */
// Front end: takes requests, classifies them against the table size and
// address zero and pushes them into the queue unless it is full. Depends on dvrt_pkg.
`default_nettype none

module dvrt_front
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DVRT_TABLE_DEPTH
) (
    input  wire logic  start,
    input  wire req_t  req,
    input  wire logic  q_full,
    output logic       busy,
    output logic       push,
    output item_t      push_item
);

    localparam logic [ADDR_W:0] DEPTH_LIM = (ADDR_W + 1)'(TABLE_DEPTH);

    assign busy = q_full;
    assign push = start && !q_full;

    always_comb
    begin
        push_item.req       = req;
        push_item.in_table  = ({1'b0, req.dest_addr} < DEPTH_LIM);
        push_item.dest_zero = (req.dest_addr == '0);
    end

endmodule

`default_nettype wire

/* rtl/dvrt_queue.sv */
// Short queue between the front end and the table engine.
// Depends on dvrt_pkg and the assertion macro header.
`default_nettype none
`include "distance_vector_route_table_assert.svh"

module dvrt_queue
    import dvrt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

    `DVRT_ASSERT_NOW(a_q_no_overflow, clk, rst_n, push, !full, "queue pushed while full")
    `DVRT_ASSERT_NOW(a_q_no_underflow, clk, rst_n, pop, !empty, "queue popped while empty")
    `DVRT_ASSERT_NOW(a_q_count_range, clk, rst_n, 1'b1, count_reg <= FULL_CNT, "queue count out of range")

endmodule

`default_nettype wire

/* rtl/dvrt_back.sv */
// Table engine: pops classified requests, reads the route entry and local
// mark, applies the command and issues one result. Depends on dvrt_pkg and
// the assertion macro header.
`default_nettype none
`include "distance_vector_route_table_assert.svh"

module dvrt_back
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DVRT_TABLE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [COST_W-1:0] inf_cost,
    input  wire item_t             head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   done,
    output rsp_t                   rsp
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int ADDR_CNT = 1 << ADDR_W;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EXEC = 2'b10
    } bk_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] hop;
        logic [COST_W-1:0] cost;
    } entry_t;

    bk_state_t           state_reg, state_next;
    entry_t              mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ADDR_CNT-1:0] local_reg;

    item_t               cur_reg;
    entry_t              ent_reg;
    logic                ent_valid_reg;
    logic                local_hit_reg;

    logic                done_reg;
    rsp_t                rsp_reg;

    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    cur_idx;
    logic                wr_en;
    entry_t              wr_ent;
    status_t             status;
    logic                new_valid;
    logic [COST_W-1:0]   inc_cost;
    rsp_t                rsp_next;

    assign pop     = (state_reg == BK_IDLE) && !empty;
    assign rd_idx  = head.req.dest_addr[IDX_W-1:0];
    assign cur_idx = cur_reg.req.dest_addr[IDX_W-1:0];
    assign done    = done_reg;
    assign rsp     = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (pop) state_next = BK_EXEC;
            BK_EXEC: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Command evaluation on the entry read in the previous cycle.
    always_comb
    begin
        status   = STS_DONE;
        wr_en    = 1'b0;
        wr_ent   = ent_reg;
        inc_cost = sat_inc(cur_reg.req.adv_cost, inf_cost);
        case (cur_reg.req.cmd)
            CMD_LOCAL:
            begin
                if (cur_reg.in_table)
                begin
                    wr_en       = 1'b1;
                    wr_ent.hop  = cur_reg.req.dest_addr;
                    wr_ent.cost = '0;
                end
                else
                    status = STS_UNKNOWN;
            end
            CMD_ADV:
            begin
                if (local_hit_reg)
                    status = STS_SKIPPED;
                else if (!cur_reg.in_table)
                    status = STS_UNKNOWN;
                else if (!ent_valid_reg)
                begin
                    wr_en       = 1'b1;
                    wr_ent.hop  = cur_reg.req.src_addr;
                    wr_ent.cost = inc_cost;
                end
                else if (cur_reg.req.adv_cost == inf_cost)
                begin
                    wr_en       = 1'b1;
                    wr_ent.cost = inf_cost;
                end
                else if (inc_cost <= ent_reg.cost)
                begin
                    wr_en       = 1'b1;
                    wr_ent.hop  = cur_reg.req.src_addr;
                    wr_ent.cost = inc_cost;
                end
            end
            CMD_LOOKUP:
            begin
                if (cur_reg.dest_zero)
                    status = STS_ZERO;
                else if (!cur_reg.in_table || !ent_valid_reg)
                    status = STS_UNKNOWN;
            end
            CMD_DOWN:
            begin
                if (!cur_reg.in_table || !ent_valid_reg)
                    status = STS_UNKNOWN;
                else
                begin
                    wr_en       = 1'b1;
                    wr_ent.cost = inf_cost;
                end
            end
            default: status = STS_DONE;
        endcase

        new_valid       = ent_valid_reg || wr_en;
        rsp_next.status = status;
        if (status != STS_ZERO && cur_reg.in_table && new_valid)
        begin
            rsp_next.route_hop  = wr_ent.hop;
            rsp_next.route_cost = wr_ent.cost;
        end
        else
        begin
            rsp_next.route_hop  = '0;
            rsp_next.route_cost = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            valid_reg <= '0;
            local_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == BK_EXEC);
            if (state_reg == BK_EXEC)
            begin
                if (wr_en)
                    valid_reg[cur_idx] <= 1'b1;
                if (cur_reg.req.cmd == CMD_LOCAL)
                    local_reg[cur_reg.req.dest_addr] <= 1'b1;
            end
        end
    end

    // Entry storage and per-request read registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg       <= head;
            ent_reg       <= mem[rd_idx];
            ent_valid_reg <= valid_reg[rd_idx];
            local_hit_reg <= local_reg[head.req.adv_hop];
        end
        if (state_reg == BK_EXEC && wr_en)
            mem[cur_idx] <= wr_ent;
        if (state_reg == BK_EXEC)
            rsp_reg <= rsp_next;
    end

    `DVRT_ASSERT_NEXT(a_bk_exec_done, clk, rst_n, state_reg == BK_EXEC, done_reg, "no result after execute")
    `DVRT_ASSERT_NEXT(a_bk_single_done, clk, rst_n, done_reg, !done_reg, "result strobe held two cycles")
    `DVRT_ASSERT_NOW(a_bk_zero_rsp, clk, rst_n, done_reg && rsp_reg.status == STS_ZERO, rsp_reg.route_hop == '0 && rsp_reg.route_cost == '0, "address zero result carries data")

endmodule

`default_nettype wire

/* rtl/distance_vector_route_table.sv */
// Channel   | Handshake                          | Payload
// request   | start, accepted when busy is low   | req (req_t)
// result    | done, one cycle, no back-pressure  | rsp (rsp_t)
// config    | APB write: psel&penable&pwrite     | pwdata[7:0] -> infinity cost (paddr[2]=0)
//
// A request enters the queue; the table engine pops it once idle and
// registers the route entry and local mark, then writes back and registers
// the result, and done is raised from a register. The engine takes no new
// request until it has written back the last, because of the
// read-modify-write of the route memory. Reset clears the valid bits and
// local marks at once. busy rises when the request queue is full; results
// cannot be stalled.
//
// Top level of the distance-vector route table. Depends on dvrt_pkg,
// dvrt_front, dvrt_queue and dvrt_back.
`default_nettype none

module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DVRT_TABLE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire req_t        req,
    output logic             busy,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic              q_full;
    logic              q_empty;
    logic              push;
    logic              pop;
    item_t             push_item;
    item_t             head;
    logic [COST_W-1:0] inf_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_INF) ? {{(32 - COST_W){1'b0}}, inf_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inf_reg <= '1;
        else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_INF)
            inf_reg <= pwdata[COST_W-1:0];
    end

    dvrt_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .start     (start),
        .req       (req),
        .q_full    (q_full),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    dvrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    dvrt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .inf_cost (inf_reg),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire
